// ===== design/ustc_pkg.sv =====
package ustc_pkg;

    // Register stages from the input register through the result register
    localparam int STAGES = 8;

    typedef logic [STAGES:1] t_stage_en;

    // Seconds to days: x / 86400 == (x >> 7) / 675
    localparam logic [9:0]  DAY_HI      = 10'd675;
    localparam logic [25:0] RECIP_675   = 26'd50903317;   // ceil(2^35 / 675)

    // Julian day number plus the 32044 shift, relative to the epoch day
    localparam logic [21:0] JDN_BIAS    = 22'd2472632;
    localparam logic [15:0] WDAY_BIAS   = 16'd3;          // 1970-01-01 was a Thursday
    localparam logic [15:0] WEEK_DAYS   = 16'd7;
    localparam logic [16:0] RECIP_7     = 17'd74899;      // ceil(2^19 / 7)

    // Time of day: x / 3600 == (x >> 4) / 225, x / 60 == (x >> 2) / 15
    localparam logic [13:0] RECIP_225   = 14'd9321;       // ceil(2^21 / 225)
    localparam logic [16:0] HOUR_SEC    = 17'd3600;
    localparam logic [10:0] RECIP_15    = 11'd1093;       // ceil(2^14 / 15)
    localparam logic [11:0] MIN_SEC     = 12'd60;

    // Century selection on 4a+3 against multiples of 146097
    localparam logic [23:0] CENT68_LIM  = 24'd9934596;
    localparam logic [23:0] CENT69_LIM  = 24'd10080693;
    localparam logic [1:0]  CENT_19     = 2'd0;
    localparam logic [1:0]  CENT_20     = 2'd1;
    localparam logic [1:0]  CENT_21     = 2'd2;

    localparam logic [18:0] RECIP_1461  = 19'd367469;     // ceil(2^29 / 1461)
    localparam logic [17:0] QUAD_DAYS   = 18'd1461;
    localparam logic [11:0] RECIP_153   = 12'd3427;       // ceil(2^19 / 153)
    localparam logic [3:0]  MON5_JAN    = 4'd10;

    // floor(146097 * century / 4)
    function automatic logic [21:0] f_cent_days(input logic [1:0] idx);
        logic [21:0] days;
        unique case (idx)
            CENT_19: days = 22'd2447124;
            CENT_20: days = 22'd2483649;
            CENT_21: days = 22'd2520173;
            default: days = 22'd0;
        endcase
        return days;
    endfunction

    // 100 * century - 4800
    function automatic logic [11:0] f_year_base(input logic [1:0] idx);
        logic [11:0] year;
        unique case (idx)
            CENT_19: year = 12'd1900;
            CENT_20: year = 12'd2000;
            CENT_21: year = 12'd2100;
            default: year = 12'd0;
        endcase
        return year;
    endfunction

    // (153 * m + 2) / 5, months counted from March
    function automatic logic [8:0] f_month_start(input logic [3:0] mon5);
        logic [8:0] start;
        unique case (mon5)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ===== design/ustc_day_split.sv =====
module ustc_day_split (
    input  logic                 i_clk,
    input  ustc_pkg::t_stage_en  i_en,
    input  logic [31:0]          i_seconds,
    output logic [15:0]          o_days,
    output logic [16:0]          o_tod
);

    logic [50:0] r_prod;
    logic [50:0] n_prod;
    logic [24:0] r_hi;
    logic [6:0]  r_lo;

    logic [15:0] n_days;
    logic [25:0] n_day_sec;
    logic [24:0] n_rem;
    logic [16:0] n_tod;

    assign n_prod = 51'(i_seconds[31:7]) * 51'(ustc_pkg::RECIP_675);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_prod <= n_prod;
            r_hi   <= i_seconds[31:7];
            r_lo   <= i_seconds[6:0];
        end
    end

    always_comb begin
        n_days    = r_prod[50:35];
        n_day_sec = 26'(n_days) * 26'(ustc_pkg::DAY_HI);
        n_rem     = r_hi - n_day_sec[24:0];
        n_tod     = {n_rem[9:0], r_lo};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_days <= n_days;
            o_tod  <= n_tod;
        end
    end

endmodule

// ===== design/ustc_clock.sv =====
module ustc_clock (
    input  logic                 i_clk,
    input  ustc_pkg::t_stage_en  i_en,
    input  logic [15:0]          i_days,
    input  logic [16:0]          i_tod,
    output logic [2:0]           o_weekday,
    output logic [4:0]           o_hour,
    output logic [5:0]           o_minute,
    output logic [5:0]           o_second
);

    // stage 4
    logic [26:0] r_hp;
    logic [26:0] n_hp;
    logic [16:0] r_tod4;
    logic [15:0] r_wx;
    logic [15:0] n_wx;
    logic [32:0] r_wp;
    logic [32:0] n_wp;

    // stage 5
    logic [4:0]  n_hour;
    logic [16:0] n_hsec;
    logic [16:0] n_r1w;
    logic [13:0] n_wq;
    logic [15:0] n_wmul;
    logic [15:0] n_wdw;
    logic [11:0] r_r1;
    logic [4:0]  r_hour5;
    logic [2:0]  r_wd5;

    // stage 6
    logic [20:0] r_mp;
    logic [20:0] n_mp;
    logic [11:0] r_r16;
    logic [4:0]  r_hour6;
    logic [2:0]  r_wd6;

    // stage 7
    logic [5:0]  n_min;
    logic [11:0] n_msec;
    logic [11:0] n_secw;
    logic [5:0]  r_min7;
    logic [5:0]  r_sec7;
    logic [4:0]  r_hour7;
    logic [2:0]  r_wd7;

    always_comb begin
        n_hp = 27'(i_tod[16:4]) * 27'(ustc_pkg::RECIP_225);
        n_wx = i_days + ustc_pkg::WDAY_BIAS;
        n_wp = 33'(n_wx) * 33'(ustc_pkg::RECIP_7);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_hp   <= n_hp;
            r_tod4 <= i_tod;
            r_wx   <= n_wx;
            r_wp   <= n_wp;
        end
    end

    always_comb begin
        n_hour = r_hp[25:21];
        n_hsec = 17'(n_hour) * ustc_pkg::HOUR_SEC;
        n_r1w  = r_tod4 - n_hsec;
        n_wq   = r_wp[32:19];
        n_wmul = 16'(n_wq) * ustc_pkg::WEEK_DAYS;
        n_wdw  = r_wx - n_wmul;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_r1    <= n_r1w[11:0];
            r_hour5 <= n_hour;
            r_wd5   <= n_wdw[2:0];
        end
    end

    assign n_mp = 21'(r_r1[11:2]) * 21'(ustc_pkg::RECIP_15);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_mp    <= n_mp;
            r_r16   <= r_r1;
            r_hour6 <= r_hour5;
            r_wd6   <= r_wd5;
        end
    end

    always_comb begin
        n_min  = r_mp[19:14];
        n_msec = 12'(n_min) * ustc_pkg::MIN_SEC;
        n_secw = r_r16 - n_msec;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_min7  <= n_min;
            r_sec7  <= n_secw[5:0];
            r_hour7 <= r_hour6;
            r_wd7   <= r_wd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            o_weekday <= r_wd7;
            o_hour    <= r_hour7;
            o_minute  <= r_min7;
            o_second  <= r_sec7;
        end
    end

endmodule

// ===== design/ustc_date.sv =====
module ustc_date (
    input  logic                 i_clk,
    input  ustc_pkg::t_stage_en  i_en,
    input  logic [15:0]          i_days,
    output logic [11:0]          o_year,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day_of_month
);

    // stage 4
    logic [21:0] n_a;
    logic [23:0] n_a4;
    logic [1:0]  n_cidx;
    logic [21:0] n_a1w;
    logic [15:0] r_a1;
    logic [1:0]  r_cidx4;

    // stage 5
    logic [36:0] r_qp;
    logic [36:0] n_qp;
    logic [15:0] r_a15;
    logic [1:0]  r_cidx5;

    // stage 6
    logic [6:0]  n_quad;
    logic [17:0] n_qd;
    logic [15:0] n_a2w;
    logic [8:0]  r_a2;
    logic [6:0]  r_quad6;
    logic [1:0]  r_cidx6;

    // stage 7
    logic [10:0] n_m5x;
    logic [22:0] r_mp;
    logic [22:0] n_mp;
    logic [8:0]  r_a27;
    logic [6:0]  r_quad7;
    logic [1:0]  r_cidx7;

    // stage 8
    logic [3:0]  n_mon5;
    logic        n_late;
    logic [8:0]  n_mday;
    logic [3:0]  n_month;
    logic [11:0] n_year;

    always_comb begin
        n_a  = 22'(i_days) + ustc_pkg::JDN_BIAS;
        n_a4 = {n_a, 2'b11};
        if (n_a4 >= ustc_pkg::CENT69_LIM) begin
            n_cidx = ustc_pkg::CENT_21;
        end else if (n_a4 >= ustc_pkg::CENT68_LIM) begin
            n_cidx = ustc_pkg::CENT_20;
        end else begin
            n_cidx = ustc_pkg::CENT_19;
        end
        n_a1w = n_a - ustc_pkg::f_cent_days(n_cidx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_a1    <= n_a1w[15:0];
            r_cidx4 <= n_cidx;
        end
    end

    assign n_qp = 37'({r_a1, 2'b11}) * 37'(ustc_pkg::RECIP_1461);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_qp    <= n_qp;
            r_a15   <= r_a1;
            r_cidx5 <= r_cidx4;
        end
    end

    always_comb begin
        n_quad = r_qp[35:29];
        n_qd   = 18'(n_quad) * ustc_pkg::QUAD_DAYS;
        n_a2w  = r_a15 - n_qd[17:2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_a2    <= n_a2w[8:0];
            r_quad6 <= n_quad;
            r_cidx6 <= r_cidx5;
        end
    end

    always_comb begin
        n_m5x = 11'(r_a2) * 11'd5 + 11'd2;
        n_mp  = 23'(n_m5x) * 23'(ustc_pkg::RECIP_153);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_mp    <= n_mp;
            r_a27   <= r_a2;
            r_quad7 <= r_quad6;
            r_cidx7 <= r_cidx6;
        end
    end

    // months counted from March; January and February belong to the next year
    always_comb begin
        n_mon5 = r_mp[22:19];
        n_late = (n_mon5 >= ustc_pkg::MON5_JAN);
        n_mday = r_a27 - ustc_pkg::f_month_start(n_mon5) + 9'd1;
        if (n_late) begin
            n_month = n_mon5 - 4'd9;
        end else begin
            n_month = n_mon5 + 4'd3;
        end
        n_year = ustc_pkg::f_year_base(r_cidx7) + 12'(r_quad7) + 12'(n_late);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            o_year         <= n_year;
            o_month        <= n_month;
            o_day_of_month <= n_mday[4:0];
        end
    end

endmodule

// ===== design/unix_seconds_to_calendar.sv =====
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, weekday (0 Monday .. 6 Sunday) and time of day.
//
// Input channel: i_valid / o_stall with i_seconds_since_epoch. A transfer
// happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the seven result fields, one
// result per input, in order.
//
// Eight register stages, input register to result register. One item
// per cycle is taken while the outputs are consumed; the depth is set by
// the constant-reciprocal multiplies.
//
// When i_stall holds a result, stages behind it keep moving until they run
// into occupied stages; o_stall rises only once every stage holds an item.
// Reset (synchronous, active low) empties the pipeline; no item is lost or
// duplicated across a stall.
module unix_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seconds_since_epoch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    ustc_pkg::t_stage_en r_valid;
    ustc_pkg::t_stage_en stage_en;

    logic [31:0] r_seconds;
    logic [15:0] days;
    logic [16:0] tod;

    // a stage moves when empty or when the one after it moves
    always_comb begin
        stage_en[ustc_pkg::STAGES] = !r_valid[ustc_pkg::STAGES] || !i_stall;
        for (int k = ustc_pkg::STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[1]) begin
                r_valid[1] <= i_valid;
            end
            for (int k = 2; k <= ustc_pkg::STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_seconds <= i_seconds_since_epoch;
        end
    end

    ustc_day_split u_day_split (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_seconds (r_seconds),
        .o_days    (days),
        .o_tod     (tod)
    );

    ustc_date u_date (
        .i_clk          (i_clk),
        .i_en           (stage_en),
        .i_days         (days),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    ustc_clock u_clock (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_days    (days),
        .i_tod     (tod),
        .o_weekday (o_weekday),
        .o_hour    (o_hour),
        .o_minute  (o_minute),
        .o_second  (o_second)
    );

    assign o_valid = r_valid[ustc_pkg::STAGES];
    assign o_stall = !stage_en[1];

endmodule

// ===== design/ustc_checker.sv =====
module ustc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_seconds_since_epoch,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [11:0] o_year,
    input  logic [3:0]  o_month,
    input  logic [4:0]  o_day_of_month,
    input  logic [2:0]  o_weekday,
    input  logic [4:0]  o_hour,
    input  logic [5:0]  o_minute,
    input  logic [5:0]  o_second
);

    // no back-pressure upstream unless the output is held
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output side is free");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_valid && i_stall) |=> (o_valid && $stable(o_year) && $stable(o_month)
            && $stable(o_day_of_month) && $stable(o_weekday) && $stable(o_hour)
            && $stable(o_minute) && $stable(o_second)))
        else $error("held result changed");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month >= 5'd1
            && o_year >= 12'd1970 && o_year <= 12'd2106 && o_weekday <= 3'd6))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("time field out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_checker (.*);

// ===== bench/calendar_checker.sv =====
module calendar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_seconds,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] SEC_PER_DAY   = 64'd86400;
    localparam logic [63:0] SEC_PER_HOUR  = 64'd3600;
    localparam logic [63:0] SEC_PER_MIN   = 64'd60;
    localparam logic [63:0] EPOCH_JDN     = 64'd2440588;
    localparam logic [63:0] JDN_OFFSET    = 64'd32044;
    localparam logic [63:0] DAYS_400Y     = 64'd146097;
    localparam logic [63:0] DAYS_4Y       = 64'd1461;
    localparam logic [63:0] DAYS_5M       = 64'd153;
    localparam logic [63:0] YEAR_OFFSET   = 64'd4800;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    t_calendar expected_dates[$];
    int        mismatches = 0;

    function automatic t_calendar calendar_of(input logic [31:0] secs);
        logic [63:0] tod;
        logic [63:0] jdn;
        logic [63:0] days;
        logic [63:0] cent;
        logic [63:0] quad;
        logic [63:0] mon5;
        logic [63:0] jan_feb;
        t_calendar   cal;
        tod  = {32'd0, secs} % SEC_PER_DAY;
        jdn  = {32'd0, secs} / SEC_PER_DAY + EPOCH_JDN;
        days = jdn + JDN_OFFSET;
        cent = (4 * days + 3) / DAYS_400Y;
        days = days - (DAYS_400Y * cent) / 4;
        quad = (4 * days + 3) / DAYS_4Y;
        days = days - (DAYS_4Y * quad) / 4;
        mon5 = (5 * days + 2) / DAYS_5M;
        jan_feb = mon5 / 10;
        cal.year   = 12'(100 * cent + quad + jan_feb - YEAR_OFFSET);
        cal.month  = 4'(mon5 + 3 - 12 * jan_feb);
        cal.mday   = 5'(days - (DAYS_5M * mon5 + 2) / 5 + 1);
        cal.wday   = 3'(jdn % 7);
        cal.hour   = 5'(tod / SEC_PER_HOUR);
        cal.minute = 6'((tod % SEC_PER_HOUR) / SEC_PER_MIN);
        cal.second = 6'((tod % SEC_PER_HOUR) % SEC_PER_MIN);
        return cal;
    endfunction

    always @(posedge i_clk) begin
        t_calendar got;
        t_calendar want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_year, i_month, i_day_of_month, i_weekday, i_hour, i_minute,
                       i_second};
                if (expected_dates.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                                 got.year, got.month, got.mday, got.wday, got.hour,
                                 got.minute, got.second);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (got != want) begin
                        if (mismatches < 10) begin
                            $write("mismatch: expected %0d-%0d-%0d wd %0d %0d:%0d:%0d,",
                                   want.year, want.month, want.mday, want.wday, want.hour,
                                   want.minute, want.second);
                            $display(" got %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                                     got.year, got.month, got.mday, got.wday, got.hour,
                                     got.minute, got.second);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_dates.push_back(calendar_of(i_seconds));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_dates.size();
    end

endmodule

// ===== bench/unix_seconds_to_calendar_tb.sv =====
module unix_seconds_to_calendar_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 270;
    localparam int HOLD_CYCLES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_seconds_since_epoch = 32'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [2:0]  o_weekday;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit long_hold = 1'b0;
    bit hold_served = 1'b0;

    logic [31:0] edge_seconds [0:21];

    always #2 i_clk = ~i_clk;

    unix_seconds_to_calendar DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_seconds_since_epoch (i_seconds_since_epoch),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_year                (o_year),
        .o_month               (o_month),
        .o_day_of_month        (o_day_of_month),
        .o_weekday             (o_weekday),
        .o_hour                (o_hour),
        .o_minute              (o_minute),
        .o_second              (o_second)
    );

    calendar_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_seconds      (i_seconds_since_epoch),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_year         (o_year),
        .i_month        (o_month),
        .i_day_of_month (o_day_of_month),
        .i_weekday      (o_weekday),
        .i_hour         (o_hour),
        .i_minute       (o_minute),
        .i_second       (o_second),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver side; one long hold-off to back the pipeline up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (long_hold && !hold_served) begin
            i_stall     <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [31:0] random_seconds();
        logic [31:0] day;
        logic [31:0] secs;
        case ($urandom_range(4))
            0, 1: secs = $urandom;
            2: begin
                day  = $urandom_range(49709);
                secs = day * 32'd86400 + ($urandom_range(1) ? $urandom_range(59)
                                                             : 86399 - $urandom_range(59));
            end
            3: secs = 32'hFFFF_FFFF - $urandom_range(200000);
            default: secs = $urandom_range(100000000);
        endcase
        return secs;
    endfunction

    task automatic push_seconds(input logic [31:0] secs);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_seconds_since_epoch <= secs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) push_seconds(random_seconds());
    endtask

    initial begin
        edge_seconds = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd43199,
                         32'd43200, 32'd86399, 32'd86400, 32'd68169600, 32'd951782400,
                         32'd946684799, 32'd946684800, 32'd4102444799, 32'd4107542399,
                         32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                         32'h5555_5555, 32'hFFFF_FFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_seconds[k]) push_seconds(edge_seconds[k]);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(48, 0, PHASE_ITEMS);
        run_phase(0, 48, PHASE_ITEMS);
        run_phase(21, 21, PHASE_ITEMS);

        long_hold = 1'b1;
        run_phase(0, 0, 40);

        i_valid   <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
